/* design/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared types, tag codes, request codes and a helper function.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int DEF_TREE_LEVELS = 9;
    localparam int CNT_W           = 16;
    localparam int IDX_W           = 16;
    localparam int ADDR_MAX_W      = 16;

    typedef logic [1:0] t_tag;

    localparam t_tag TAG_LINK = 2'd0;
    localparam t_tag TAG_FREE = 2'd1;
    localparam t_tag TAG_USED = 2'd2;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_ACQ = 2'd0;
    localparam t_kind KIND_REL = 2'd1;
    localparam t_kind KIND_CLR = 2'd2;

    // One access of the tag memory: one write port and one read port.
    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] waddr;
        t_tag                  wdata;
        logic [ADDR_MAX_W-1:0] raddr;
    } t_mem_req;

    // Number of significant bits of a value (zero gives zero).
    function automatic logic [4:0] bit_len(input logic [CNT_W-1:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                n = 5'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

/* design/bba_tag_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator tag memory
// One tag per tree node, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_tag_ram
    import bba_pkg::*;
#(
    parameter int TREE_LEVELS = DEF_TREE_LEVELS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_tag     o_rdata,
    output logic     o_root_free
);

    localparam int NODE_W     = TREE_LEVELS;
    localparam int NODE_COUNT = (1 << TREE_LEVELS) - 1;

    t_tag r_mem [NODE_COUNT];
    t_tag r_rdata;
    logic r_root_free;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[NODE_W-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr[NODE_W-1:0]];
    end

    // The tree holds nothing exactly when the root is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_free <= 1'b0;
        end else if (i_req.we && (i_req.waddr[NODE_W-1:0] == '0)) begin
            r_root_free <= (i_req.wdata == TAG_FREE);
        end
    end

    assign o_rdata     = r_rdata;
    assign o_root_free = r_root_free;

endmodule

/* design/bba_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator sequencer
// Walks the tag tree one node access at a time for acquire, release, clear.
// ----------------------------------------------------------------------------
module bba_seq
    import bba_pkg::*;
#(
    parameter int TREE_LEVELS = DEF_TREE_LEVELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_kind,
    input  logic [CNT_W-1:0]      i_request_count,
    input  logic [IDX_W-1:0]      i_start_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_ok,
    output logic [((TREE_LEVELS > 1) ? TREE_LEVELS - 1 : 1)-1:0] o_block_start,
    output logic [TREE_LEVELS-1:0] o_block_size,
    output logic                  o_empty_res,
    output t_mem_req              o_req,
    input  t_tag                  i_rdata,
    input  logic                  i_root_free
);

    localparam int NODE_W  = TREE_LEVELS;
    localparam int START_W = (TREE_LEVELS > 1) ? TREE_LEVELS - 1 : 1;
    localparam int SIZE_W  = TREE_LEVELS;
    localparam int LVL_W   = $clog2(TREE_LEVELS + 1);
    localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'((1 << TREE_LEVELS) - 2);
    localparam logic [LVL_W-1:0]  LVL_TOP   = LVL_W'(TREE_LEVELS - 1);
    localparam logic [CNT_W:0]    LEAF_CNT  = (CNT_W + 1)'(1 << (TREE_LEVELS - 1));

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_SCAN_RD = 4'd2;
    localparam logic [3:0] S_SCAN_EV = 4'd3;
    localparam logic [3:0] S_SPL0    = 4'd4;
    localparam logic [3:0] S_SPL1    = 4'd5;
    localparam logic [3:0] S_SPL2    = 4'd6;
    localparam logic [3:0] S_REL_CHK = 4'd7;
    localparam logic [3:0] S_REL_EV  = 4'd8;
    localparam logic [3:0] S_MRG_CHK = 4'd9;
    localparam logic [3:0] S_MRG_EV  = 4'd10;
    localparam logic [3:0] S_MRG_W2  = 4'd11;
    localparam logic [3:0] S_RESP    = 4'd12;

    logic [3:0]         r_state, n_state;
    logic [NODE_W-1:0]  r_node, n_node;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [LVL_W-1:0]   r_tlvl, n_tlvl;
    logic               r_search, n_search;
    logic               r_retake, n_retake;
    logic               r_item, n_item;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_res_ok, n_res_ok;
    logic [START_W-1:0] r_res_start, n_res_start;
    logic [SIZE_W-1:0]  r_res_size, n_res_size;
    logic               r_out_valid, n_out_valid;
    logic               r_ok;
    logic [START_W-1:0] r_start;
    logic [SIZE_W-1:0]  r_size;
    logic               r_empty;

    function automatic logic [NODE_W-1:0] lvl_first(input logic [LVL_W-1:0] l);
        return (NODE_W'(1) << l) - NODE_W'(1);
    endfunction

    logic [LVL_W-1:0]  sh;
    logic [NODE_W-1:0] first_n;
    logic [NODE_W-1:0] last_n;
    logic [SIZE_W-1:0] span;
    logic [NODE_W-1:0] mate;
    logic [IDX_W-1:0]  rel_off;
    logic              rel_aligned;
    logic [NODE_W-1:0] rel_node;
    logic [NODE_W-1:0] left_n;
    logic [4:0]        acq_lg;
    logic [CNT_W-1:0]  acq_cnt;
    logic              in_acc;
    logic              load_out;

    always_comb begin
        sh          = LVL_TOP - r_lvl;
        first_n     = lvl_first(r_lvl);
        last_n      = first_n + (NODE_W'(1) << r_lvl) - NODE_W'(1);
        span        = SIZE_W'(1) << sh;
        mate        = r_node[0] ? r_node + NODE_W'(1) : r_node - NODE_W'(1);
        rel_off     = r_idx >> sh;
        rel_aligned = ((r_idx & ((IDX_W'(1) << sh) - IDX_W'(1))) == '0);
        rel_node    = first_n + rel_off[NODE_W-1:0];
        left_n      = {r_node[NODE_W-2:0], 1'b1};
        acq_cnt     = (i_request_count == '0) ? CNT_W'(1) : i_request_count;
        acq_lg      = bit_len(acq_cnt - CNT_W'(1));
    end

    assign in_acc   = i_in_valid && o_in_ready;
    assign load_out = (r_state == S_RESP) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_node      = r_node;
        n_lvl       = r_lvl;
        n_tlvl      = r_tlvl;
        n_search    = r_search;
        n_retake    = r_retake;
        n_item      = r_item;
        n_idx       = r_idx;
        n_res_ok    = r_res_ok;
        n_res_start = r_res_start;
        n_res_size  = r_res_size;
        o_req       = '0;
        o_req.raddr = ADDR_MAX_W'(r_node);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_ok    = 1'b0;
                    n_res_start = '0;
                    n_res_size  = '0;
                    n_idx       = i_start_index;
                    n_state     = S_RESP;
                    if (i_kind == KIND_ACQ) begin
                        if ({1'b0, i_request_count} <= LEAF_CNT) begin
                            n_tlvl   = LVL_TOP - LVL_W'(acq_lg);
                            n_lvl    = LVL_TOP - LVL_W'(acq_lg);
                            n_node   = lvl_first(LVL_TOP - LVL_W'(acq_lg));
                            n_search = 1'b0;
                            n_retake = 1'b0;
                            n_state  = S_SCAN_RD;
                        end
                    end else if (i_kind == KIND_REL) begin
                        n_lvl   = '0;
                        n_state = S_REL_CHK;
                    end else if (i_kind == KIND_CLR) begin
                        n_res_ok = 1'b1;
                        n_node   = '0;
                        n_item   = 1'b1;
                        n_state  = S_CLR;
                    end
                end
            end
            S_CLR: begin
                o_req.we    = 1'b1;
                o_req.waddr = ADDR_MAX_W'(r_node);
                o_req.wdata = (r_node == '0) ? TAG_FREE : TAG_LINK;
                if (r_node == NODE_LAST) begin
                    n_state = r_item ? S_RESP : S_IDLE;
                end else begin
                    n_node = r_node + NODE_W'(1);
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                n_state = S_SCAN_RD;
                if (i_rdata == TAG_FREE) begin
                    if (r_search) begin
                        n_state = S_SPL0;
                    end else begin
                        o_req.we    = 1'b1;
                        o_req.waddr = ADDR_MAX_W'(r_node);
                        o_req.wdata = TAG_USED;
                        n_res_ok    = 1'b1;
                        n_res_start = START_W'((r_node - first_n) << sh);
                        n_res_size  = span;
                        n_state     = S_RESP;
                    end
                end else if (r_node == last_n) begin
                    // End of a level: start or move the split search up, or give up.
                    if (r_search) begin
                        if (r_lvl == '0) begin
                            n_state = S_RESP;
                        end else begin
                            n_lvl  = r_lvl - LVL_W'(1);
                            n_node = lvl_first(r_lvl - LVL_W'(1));
                        end
                    end else if (r_retake || (r_tlvl == '0)) begin
                        n_state = S_RESP;
                    end else begin
                        n_search = 1'b1;
                        n_lvl    = r_tlvl - LVL_W'(1);
                        n_node   = lvl_first(r_tlvl - LVL_W'(1));
                    end
                end else begin
                    n_node = r_node + NODE_W'(1);
                end
            end
            S_SPL0: begin
                o_req.we    = 1'b1;
                o_req.waddr = ADDR_MAX_W'(r_node);
                o_req.wdata = TAG_LINK;
                n_state     = S_SPL1;
            end
            S_SPL1: begin
                o_req.we    = 1'b1;
                o_req.waddr = ADDR_MAX_W'(left_n);
                o_req.wdata = TAG_FREE;
                n_state     = S_SPL2;
            end
            S_SPL2: begin
                o_req.we    = 1'b1;
                o_req.waddr = ADDR_MAX_W'(left_n + NODE_W'(1));
                o_req.wdata = TAG_FREE;
                if ((r_lvl + LVL_W'(1)) < r_tlvl) begin
                    n_node  = left_n;
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_state = S_SPL0;
                end else begin
                    n_search = 1'b0;
                    n_retake = 1'b1;
                    n_lvl    = r_tlvl;
                    n_node   = lvl_first(r_tlvl);
                    n_state  = S_SCAN_RD;
                end
            end
            S_REL_CHK: begin
                o_req.raddr = ADDR_MAX_W'(rel_node);
                if (rel_aligned) begin
                    if ((rel_off >> r_lvl) != '0) begin
                        n_state = S_RESP;
                    end else begin
                        n_node  = rel_node;
                        n_state = S_REL_EV;
                    end
                end else begin
                    n_lvl = r_lvl + LVL_W'(1);
                end
            end
            S_REL_EV: begin
                if (i_rdata == TAG_USED) begin
                    n_res_ok   = 1'b1;
                    n_res_size = span;
                    n_state    = S_MRG_CHK;
                end else if (r_lvl == LVL_TOP) begin
                    n_state = S_RESP;
                end else begin
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_state = S_REL_CHK;
                end
            end
            S_MRG_CHK: begin
                o_req.raddr = ADDR_MAX_W'(mate);
                if (r_node == '0) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = '0;
                    o_req.wdata = TAG_FREE;
                    n_state     = S_RESP;
                end else begin
                    n_state = S_MRG_EV;
                end
            end
            S_MRG_EV: begin
                o_req.we    = 1'b1;
                o_req.waddr = ADDR_MAX_W'(r_node);
                if (i_rdata == TAG_FREE) begin
                    o_req.wdata = TAG_LINK;
                    n_state     = S_MRG_W2;
                end else begin
                    o_req.wdata = TAG_FREE;
                    n_state     = S_RESP;
                end
            end
            S_MRG_W2: begin
                o_req.we    = 1'b1;
                o_req.waddr = ADDR_MAX_W'(mate);
                o_req.wdata = TAG_LINK;
                n_node      = (r_node - NODE_W'(1)) >> 1;
                n_state     = S_MRG_CHK;
            end
            S_RESP: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_node      <= '0;
            r_item      <= 1'b0;
            r_search    <= 1'b0;
            r_retake    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_item      <= n_item;
            r_search    <= n_search;
            r_retake    <= n_retake;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl       <= n_lvl;
        r_tlvl      <= n_tlvl;
        r_idx       <= n_idx;
        r_res_ok    <= n_res_ok;
        r_res_start <= n_res_start;
        r_res_size  <= n_res_size;
        if (load_out) begin
            r_ok    <= r_res_ok;
            r_start <= r_res_start;
            r_size  <= r_res_size;
            r_empty <= i_root_free;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_block_start = r_start;
    assign o_block_size  = r_size;
    assign o_empty_res   = r_empty;

endmodule

/* design/buddy_block_allocator.sv */
`timescale 1ns / 1ps
// A clear writes every tag in turn, one tag write per cycle.
// Acquire reads and evaluates each node it scans and writes the parent and
// both children at each split step; release finds the block, then merges.
// Throughput: one transaction at a time, bound by the single tag memory.
// Reset sweeps every tag before the first transaction.
// ----------------------------------------------------------------------------
// Buddy block allocator
// Top level: tag memory and the sequencer that walks it.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int TREE_LEVELS = DEF_TREE_LEVELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_kind,
    input  logic [CNT_W-1:0]      i_request_count,
    input  logic [IDX_W-1:0]      i_start_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_ok,
    output logic [((TREE_LEVELS > 1) ? TREE_LEVELS - 1 : 1)-1:0] o_block_start,
    output logic [TREE_LEVELS-1:0] o_block_size,
    output logic                  o_empty_res
);

    t_mem_req mem_req;
    t_tag     mem_rdata;
    logic     root_free;

    bba_tag_ram #(.TREE_LEVELS(TREE_LEVELS)) u_ram (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (mem_req),
        .o_rdata     (mem_rdata),
        .o_root_free (root_free)
    );

    bba_seq #(.TREE_LEVELS(TREE_LEVELS)) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_request_count (i_request_count),
        .i_start_index   (i_start_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ok            (o_ok),
        .o_block_start   (o_block_start),
        .o_block_size    (o_block_size),
        .o_empty_res     (o_empty_res),
        .o_req           (mem_req),
        .i_rdata         (mem_rdata),
        .i_root_free     (root_free)
    );

endmodule

/* design/bba_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module bba_chk
    import bba_pkg::*;
#(
    parameter int TREE_LEVELS = DEF_TREE_LEVELS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_ok,
    input logic [((TREE_LEVELS > 1) ? TREE_LEVELS - 1 : 1)-1:0] o_block_start,
    input logic [TREE_LEVELS-1:0] o_block_size,
    input logic                  o_empty_res
);

    // The tag sweep after reset keeps the input closed.
    a_reset_sweep: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_block_size == '0 && o_block_start == '0))
        else $error("failed transaction carries a block");

    a_size_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_block_size != '0) |-> (o_ok && $onehot(o_block_size)))
        else $error("block size is not a power of two");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_ok) && $stable(o_block_size)
         && $stable(o_block_start) && $stable(o_empty_res)))
        else $error("stalled result changed");

endmodule

bind buddy_block_allocator bba_chk #(.TREE_LEVELS(TREE_LEVELS)) u_bba_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_ok          (o_ok),
    .o_block_start (o_block_start),
    .o_block_size  (o_block_size),
    .o_empty_res   (o_empty_res)
);

/* tb/tb_buddy_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives acquire, release and clear transactions through the request
// channel. Each response is compared with a behavioral model of the tag
// tree, and a set of directed rows is followed by random traffic under
// varied idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam int LEVELS = 9;
    localparam int NODES  = (1 << LEVELS) - 1;
    localparam int LEAVES = 1 << (LEVELS - 1);

    typedef struct packed {
        logic       ok;
        logic [7:0] start;
        logic [8:0] size;
        logic       empty;
    } t_resp;

    typedef struct {
        t_kind       kind;
        logic [15:0] cnt;
        logic [15:0] idx;
        logic        chk;
        t_resp       resp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = '0;
    logic [15:0] req_cnt = '0;
    logic [15:0] start_idx = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        ok;
    logic [7:0]  blk_start;
    logic [8:0]  blk_size;
    logic        empty_res;

    buddy_block_allocator #(.TREE_LEVELS(LEVELS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_kind(kind), .i_request_count(req_cnt), .i_start_index(start_idx),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_ok(ok), .o_block_start(blk_start), .o_block_size(blk_size),
        .o_empty_res(empty_res)
    );

    t_tag  tags [NODES];
    t_resp pending_resp [$];
    int    mismatches = 0;
    int    send_idle = 0;
    int    recv_stall = 0;
    int    hold_off = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void tree_reset();
        for (int n = 0; n < NODES; n++) tags[n] = TAG_LINK;
        tags[0] = TAG_FREE;
    endfunction

    function automatic bit tree_is_empty();
        if (tags[0] != TAG_FREE) return 0;
        for (int n = 1; n < NODES; n++) if (tags[n] != TAG_LINK) return 0;
        return 1;
    endfunction

    function automatic bit grab_in_level(int lvl, output int st, output int sz);
        int first;
        first = (1 << lvl) - 1;
        for (int n = first; n < first + (1 << lvl); n++) begin
            if (tags[n] == TAG_FREE) begin
                tags[n] = TAG_USED;
                st = (n - first) * (LEAVES >> lvl);
                sz = LEAVES >> lvl;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void split_down_to(int lvl);
        int first, pos, at;
        for (int cur = lvl - 1; cur >= 0; cur--) begin
            first = (1 << cur) - 1;
            for (int n = first; n < first + (1 << cur); n++) begin
                if (tags[n] == TAG_FREE) begin
                    pos = n;
                    at = cur;
                    do begin
                        tags[pos] = TAG_LINK;
                        tags[2 * pos + 1] = TAG_FREE;
                        tags[2 * pos + 2] = TAG_FREE;
                        pos = 2 * pos + 1;
                        at++;
                    end while (at < lvl);
                    return;
                end
            end
        end
    endfunction

    function automatic void free_and_merge(int pos);
        int mate;
        while (pos > 0) begin
            mate = (pos & 1) ? pos + 1 : pos - 1;
            if (tags[mate] == TAG_FREE) begin
                tags[pos] = TAG_LINK;
                tags[mate] = TAG_LINK;
                pos = (pos - 1) >> 1;
            end else begin
                tags[pos] = TAG_FREE;
                return;
            end
        end
        tags[0] = TAG_FREE;
    endfunction

    function automatic int release_block(int idx);
        int span, off;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            span = LEAVES >> lvl;
            if ((idx & (span - 1)) == 0) begin
                off = idx >> (LEVELS - lvl - 1);
                if (off >= (1 << lvl)) return 0;
                if (tags[(1 << lvl) - 1 + off] == TAG_USED) begin
                    free_and_merge((1 << lvl) - 1 + off);
                    return span;
                end
            end
        end
        return 0;
    endfunction

    function automatic t_resp allocator_step(t_kind k, int cnt, int idx);
        t_resp r;
        int st, sz, c, lg, lvl;
        bit good;
        st = 0; sz = 0; good = 0;
        if (k == KIND_ACQ) begin
            if (cnt <= LEAVES) begin
                c = (cnt == 0) ? 1 : cnt;
                lg = 0;
                while ((1 << lg) < c) lg++;
                lvl = LEVELS - lg - 1;
                good = grab_in_level(lvl, st, sz);
                if (!good && lvl > 0) begin
                    split_down_to(lvl);
                    good = grab_in_level(lvl, st, sz);
                end
                if (!good) begin
                    st = 0;
                    sz = 0;
                end
            end
        end else if (k == KIND_REL) begin
            sz = release_block(idx);
            good = (sz != 0);
        end else if (k == KIND_CLR) begin
            tree_reset();
            good = 1;
        end
        r.ok = good;
        r.start = st[7:0];
        r.size = sz[8:0];
        r.empty = tree_is_empty();
        return r;
    endfunction

    // Response side: comparison at the rising edge, stall control at the falling edge.
    always @(posedge i_clk) begin
        t_resp got, want;
        if (i_rst_n && out_valid && out_ready) begin
            got = '{ok, blk_start, blk_size, empty_res};
            if (pending_resp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected response %p", got);
            end else begin
                want = pending_resp.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Called at a falling edge; valid drops only during idle cycles, so a
    // back-to-back transaction keeps valid high with a single update.
    task automatic send_request(t_kind k, logic [15:0] c, logic [15:0] x,
                                bit chk, t_resp exp_r);
        t_resp pr;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        req_cnt <= c;
        start_idx <= x;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pr = allocator_step(k, c, x);
        if (chk && pr !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("Table row disagrees: %p vs %p", exp_r, pr);
        end
        pending_resp.push_back(pr);
        @(negedge i_clk);
    endtask

    t_row rows [] = '{
        '{KIND_ACQ, 16'd0,     16'd0,     1, '{1'b1, 8'd0, 9'd1, 1'b0}},
        '{KIND_REL, 16'd0,     16'd0,     1, '{1'b1, 8'd0, 9'd1, 1'b1}},
        '{KIND_ACQ, 16'd256,   16'd0,     1, '{1'b1, 8'd0, 9'd256, 1'b0}},
        '{KIND_ACQ, 16'd1,     16'd0,     1, '{1'b0, 8'd0, 9'd0, 1'b0}},
        '{KIND_REL, 16'd0,     16'd0,     1, '{1'b1, 8'd0, 9'd256, 1'b1}},
        '{KIND_ACQ, 16'd257,   16'd0,     1, '{1'b0, 8'd0, 9'd0, 1'b1}},
        '{KIND_ACQ, 16'hFFFF,  16'd0,     1, '{1'b0, 8'd0, 9'd0, 1'b1}},
        '{KIND_REL, 16'd0,     16'hFFFF,  1, '{1'b0, 8'd0, 9'd0, 1'b1}},
        '{KIND_REL, 16'd0,     16'd256,   1, '{1'b0, 8'd0, 9'd0, 1'b1}},
        '{2'd3,     16'hFFFF,  16'hFFFF,  1, '{1'b0, 8'd0, 9'd0, 1'b1}},
        '{KIND_ACQ, 16'd3,     16'd0,     0, '0},
        '{KIND_ACQ, 16'd1,     16'd0,     0, '0},
        '{KIND_ACQ, 16'd128,   16'd0,     0, '0},
        '{KIND_ACQ, 16'd128,   16'd0,     0, '0},
        '{KIND_REL, 16'd0,     16'd4,     0, '0},
        '{KIND_REL, 16'd0,     16'd128,   0, '0},
        '{KIND_REL, 16'd0,     16'd0,     0, '0},
        '{2'd3,     16'd0,     16'd0,     0, '0},
        '{KIND_CLR, 16'd0,     16'd0,     1, '{1'b1, 8'd0, 9'd0, 1'b1}},
        '{KIND_ACQ, 16'd255,   16'hAAAA,  1, '{1'b1, 8'd0, 9'd256, 1'b0}},
        '{KIND_CLR, 16'h5555,  16'h5555,  1, '{1'b1, 8'd0, 9'd0, 1'b1}}
    };

    initial begin
        t_kind k;
        logic [15:0] c, x;
        int pick, sel;
        tree_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send_request(rows[i].kind, rows[i].cnt, rows[i].idx, rows[i].chk,
                         rows[i].resp);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 48; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 48; end
                3: begin send_idle = 33; recv_stall = 33; end
                default: begin send_idle = 0; recv_stall = 10; hold_off = 400; end
            endcase
            for (int n = 0; n < 80; n++) begin
                pick = $urandom_range(99);
                x = 16'($urandom);
                if (pick < 50) begin
                    k = KIND_ACQ;
                    sel = $urandom_range(9);
                    if (sel < 6) c = 16'($urandom_range(8));
                    else if (sel < 9) c = 16'($urandom_range(256));
                    else c = 16'($urandom);
                end else if (pick < 88) begin
                    k = KIND_REL;
                    c = 16'($urandom);
                    if (pick < 80) x = 16'($urandom_range(255));
                    if (pick < 72) x = x & ~16'((1 << $urandom_range(8)) - 1);
                end else if (pick < 94) begin
                    k = KIND_CLR;
                    c = 16'($urandom);
                end else begin
                    k = 2'd3;
                    c = 16'($urandom);
                end
                send_request(k, c, x, 0, '0);
            end
        end
        in_valid <= 1'b0;

        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (mismatches == 0 && pending_resp.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
